// ===== hw/rtl/drmc_pkg.sv =====
// ----------------------------------------------------------------------------
// drmc_pkg
// Types and address codes shared by the compute row group.
// ----------------------------------------------------------------------------
package drmc_pkg;

   localparam int NUM_ROWS = 8;

   localparam logic KIND_AP  = 1'b0;
   localparam logic KIND_AAP = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   // Multi-row and AP addresses
   localparam logic [3:0] ADDR_T0_NDCC0 = 4'd8;
   localparam logic [3:0] ADDR_T1_NDCC1 = 4'd9;
   localparam logic [3:0] ADDR_T2_T3    = 4'd10;
   localparam logic [3:0] ADDR_T0_T3    = 4'd11;
   localparam logic [3:0] ADDR_T012     = 4'd12;
   localparam logic [3:0] ADDR_T123     = 4'd13;
   localparam logic [3:0] ADDR_DCC0_T12 = 4'd14;
   localparam logic [3:0] ADDR_DCC1_T03 = 4'd15;

   // Row indexes
   localparam logic [2:0] ROW_T0    = 3'd0;
   localparam logic [2:0] ROW_T1    = 3'd1;
   localparam logic [2:0] ROW_T2    = 3'd2;
   localparam logic [2:0] ROW_T3    = 3'd3;
   localparam logic [2:0] ROW_DCC0  = 3'd4;
   localparam logic [2:0] ROW_NDCC0 = 3'd5;
   localparam logic [2:0] ROW_DCC1  = 3'd6;
   localparam logic [2:0] ROW_NDCC1 = 3'd7;

   typedef struct packed {
      logic        kind;
      logic [3:0]  source_address;
      logic        source_external;
      logic [63:0] external_value;
      logic        dest_valid;
      logic [3:0]  dest_address;
   } req_type;

   typedef struct packed {
      logic [63:0] data;
      logic        status;
   } rsp_type;

endpackage

// ===== hw/rtl/drmc_exec.sv =====
// ----------------------------------------------------------------------------
// drmc_exec
// Executes one AP or AAP command against the row file: next row values,
// and the result transfer if the command produces one.
// ----------------------------------------------------------------------------
module drmc_exec
   import drmc_pkg::*;
#(
   parameter int ROW_BITS = 64
) (
   input  req_type                           cmd,
   input  logic [NUM_ROWS-1:0][ROW_BITS-1:0] rows,
   output logic [NUM_ROWS-1:0][ROW_BITS-1:0] rows_next,
   output logic                              has_result,
   output rsp_type                           result
);

   logic [ROW_BITS-1:0] maj_a;
   logic [ROW_BITS-1:0] maj_b;
   logic [ROW_BITS-1:0] maj_c;
   logic [ROW_BITS-1:0] maj;
   logic [ROW_BITS-1:0] val;
   logic [ROW_BITS-1:0] nval;
   logic                src_is_ap;
   logic                src_is_row;
   logic                src_ok;

   // Operand triplet of the AP addressed by the source address
   always_comb begin
      case (cmd.source_address)
         ADDR_T012: begin
            maj_a = rows[ROW_T0];
            maj_b = rows[ROW_T1];
            maj_c = rows[ROW_T2];
         end
         ADDR_T123: begin
            maj_a = rows[ROW_T1];
            maj_b = rows[ROW_T2];
            maj_c = rows[ROW_T3];
         end
         ADDR_DCC0_T12: begin
            maj_a = rows[ROW_DCC0];
            maj_b = rows[ROW_T1];
            maj_c = rows[ROW_T2];
         end
         default: begin
            maj_a = rows[ROW_DCC1];
            maj_b = rows[ROW_T0];
            maj_c = rows[ROW_T3];
         end
      endcase
   end

   assign maj        = (maj_a & maj_b) | (maj_a & maj_c) | (maj_b & maj_c);
   assign src_is_ap  = cmd.source_address >= ADDR_T012;
   assign src_is_row = !cmd.source_address[3];
   assign src_ok     = cmd.source_external || src_is_ap || src_is_row;
   assign nval       = ~val;

   always_comb begin
      if (cmd.source_external) begin
         val = cmd.external_value[ROW_BITS-1:0];
      end else if (src_is_ap) begin
         val = maj;
      end else begin
         val = rows[cmd.source_address[2:0]];
      end
   end

   always_comb begin
      rows_next     = rows;
      has_result    = 1'b0;
      result.data   = '0;
      result.status = STATUS_OK;

      // Write back the majority when this command fires an AP
      if (src_is_ap && (cmd.kind == KIND_AP || !cmd.source_external)) begin
         case (cmd.source_address)
            ADDR_T012: begin
               rows_next[ROW_T0] = maj;
               rows_next[ROW_T1] = maj;
               rows_next[ROW_T2] = maj;
            end
            ADDR_T123: begin
               rows_next[ROW_T1] = maj;
               rows_next[ROW_T2] = maj;
               rows_next[ROW_T3] = maj;
            end
            ADDR_DCC0_T12: begin
               rows_next[ROW_DCC0]  = maj;
               rows_next[ROW_T1]    = maj;
               rows_next[ROW_T2]    = maj;
               rows_next[ROW_NDCC0] = ~maj;
            end
            default: begin
               rows_next[ROW_DCC1]  = maj;
               rows_next[ROW_T0]    = maj;
               rows_next[ROW_T3]    = maj;
               rows_next[ROW_NDCC1] = ~maj;
            end
         endcase
      end

      if (cmd.kind == KIND_AP) begin
         has_result = 1'b1;
         if (src_is_ap) begin
            result.data = 64'(maj);
         end else begin
            result.status = STATUS_INVALID;
         end
      end else if (!src_ok) begin
         has_result    = 1'b1;
         result.status = STATUS_INVALID;
      end else if (!cmd.dest_valid) begin
         has_result  = 1'b1;
         result.data = 64'(val);
      end else if (!cmd.dest_address[3]) begin
         // Single row; a dual-contact row also drives its partner
         rows_next[cmd.dest_address[2:0]] = val;
         if (cmd.dest_address[2]) begin
            rows_next[{cmd.dest_address[2:1], ~cmd.dest_address[0]}] = nval;
         end
      end else begin
         case (cmd.dest_address)
            ADDR_T0_NDCC0: begin
               rows_next[ROW_T0]    = val;
               rows_next[ROW_NDCC0] = val;
               rows_next[ROW_DCC0]  = nval;
            end
            ADDR_T1_NDCC1: begin
               rows_next[ROW_T1]    = val;
               rows_next[ROW_NDCC1] = val;
               rows_next[ROW_DCC1]  = nval;
            end
            ADDR_T2_T3: begin
               rows_next[ROW_T2] = val;
               rows_next[ROW_T3] = val;
            end
            ADDR_T0_T3: begin
               rows_next[ROW_T0] = val;
               rows_next[ROW_T3] = val;
            end
            ADDR_T012: begin
               rows_next[ROW_T0] = val;
               rows_next[ROW_T1] = val;
               rows_next[ROW_T2] = val;
            end
            ADDR_T123: begin
               rows_next[ROW_T1] = val;
               rows_next[ROW_T2] = val;
               rows_next[ROW_T3] = val;
            end
            ADDR_DCC0_T12: begin
               rows_next[ROW_DCC0]  = val;
               rows_next[ROW_T1]    = val;
               rows_next[ROW_T2]    = val;
               rows_next[ROW_NDCC0] = nval;
            end
            default: begin
               rows_next[ROW_DCC1]  = val;
               rows_next[ROW_T0]    = val;
               rows_next[ROW_T3]    = val;
               rows_next[ROW_NDCC1] = nval;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/dram_row_majority_compute.sv =====
// ----------------------------------------------------------------------------
// dram_row_majority_compute
// Compute row group of a bulk-bitwise DRAM subarray: AP majority and AAP copy
// over four temporary rows and two dual-contact row pairs.
// ----------------------------------------------------------------------------
// Result path: a taken request enters the input register, then passes through
//   the command logic into the result register.
// Throughput: one command per cycle unless req_stall is high; the row file
//   updates in the same cycle the command leaves the input register.
// Reset: synchronous; clears all rows to zero and empties both registers.
module dram_row_majority_compute
   import drmc_pkg::*;
#(
   parameter int ROW_BITS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic                              stage_valid_ff;
   req_type                           stage_ff;
   logic [NUM_ROWS-1:0][ROW_BITS-1:0] rows_ff;
   logic [NUM_ROWS-1:0][ROW_BITS-1:0] rows_in;
   logic                              rsp_valid_ff;
   rsp_type                           rsp_ff;
   logic                              has_result;
   rsp_type                           result;
   logic                              advance;
   logic                              req_take;

   drmc_exec #(
      .ROW_BITS(ROW_BITS)
   ) u_exec (
      .cmd       (stage_ff),
      .rows      (rows_ff),
      .rows_next (rows_in),
      .has_result(has_result),
      .result    (result)
   );

   // Hold the staged command while its result cannot enter the output register
   assign advance   = stage_valid_ff && (!has_result || !rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rows_ff        <= '0;
      end else begin
         if (req_take) begin
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
         if (advance) begin
            rows_ff <= rows_in;
         end
         if (advance && has_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= req;
      end
      if (advance && has_result) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== sim/tb_dram_row_majority_compute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dram_row_majority_compute
// Self-checking bench for the compute row group. A table of directed AP and
// AAP commands is followed by random commands. A row-file predictor works out
// each read-out, majority and invalid-address result (a directed entry may type
// its own); every result transfer is checked in order. Result stalls are random.
// ----------------------------------------------------------------------------
module tb_dram_row_majority_compute;
   import drmc_pkg::*;

   localparam int          ROW_BITS       = 64;
   localparam logic [63:0] ROW_MASK       = {64{1'b1}} >> (64 - ROW_BITS);
   localparam logic [63:0] ALL_ONES       = {64{1'b1}};
   localparam int          CLK_PERIOD     = 10;
   localparam int          RESET_CYCLES   = 7;
   localparam int          NUM_RANDOM     = 900;
   localparam int          HOLD_AT        = 150;
   localparam int          PAUSE_AT       = 420;
   localparam int          CALM_FROM      = 780;
   localparam int          LONG_HOLD      = 60;
   localparam int          DRAIN_CYCLES   = 8;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          MAX_REPORTS    = 40;
   localparam int          NUM_DIRECTED   = 25;

   typedef struct {
      logic        kind;
      logic [3:0]  src;
      logic        ext;
      logic [63:0] value;
      logic        dv;
      logic [3:0]  dst;
      bit          typed;
      logic [63:0] data;
      logic        status;
   } dir_cmd_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   logic    hold_pulse = 1'b0;
   logic    idle_on    = 1'b1;

   logic [63:0] row_model [NUM_ROWS];
   rsp_type     pending_results [$];

   int error_count   = 0;
   int checked_count = 0;
   int ap_count      = 0;
   int aap_count     = 0;
   int write_count   = 0;
   int invalid_count = 0;
   int quiet_cycles  = 0;
   int hold_left     = 0;
   int stall_left    = 0;

   // kind, src, ext, value, dest valid, dest, typed, data, status
   dir_cmd_type directed_cmds [NUM_DIRECTED] = '{
      '{KIND_AAP, {1'b0, ROW_T0}, 1'b0, '0, 1'b0, '0, 1'b1, '0, STATUS_OK},
      '{KIND_AAP, {1'b0, ROW_NDCC1}, 1'b0, '0, 1'b0, '0, 1'b1, '0, STATUS_OK},
      '{KIND_AP, ADDR_T012, 1'b0, '0, 1'b0, '0, 1'b1, '0, STATUS_OK},
      '{KIND_AP, {1'b0, ROW_T0}, 1'b0, '0, 1'b0, '0, 1'b1, '0, STATUS_INVALID},
      '{KIND_AP, ADDR_T0_T3, 1'b1, ALL_ONES, 1'b1, ADDR_DCC1_T03,
        1'b1, '0, STATUS_INVALID},
      '{KIND_AAP, ADDR_T0_NDCC0, 1'b0, ALL_ONES, 1'b1, {1'b0, ROW_T0},
        1'b1, '0, STATUS_INVALID},
      '{KIND_AAP, ADDR_T0_T3, 1'b0, '0, 1'b0, '0, 1'b1, '0, STATUS_INVALID},
      '{KIND_AAP, ADDR_T0_NDCC0, 1'b1, ALL_ONES, 1'b0, '0, 1'b1, ALL_ONES, STATUS_OK},
      '{KIND_AAP, ADDR_T0_T3, 1'b1, '0, 1'b0, ADDR_T123, 1'b1, '0, STATUS_OK},
      '{KIND_AAP, '0, 1'b1, ALL_ONES, 1'b1, {1'b0, ROW_DCC0}, 1'b0, '0, STATUS_OK},
      '{KIND_AAP, {1'b0, ROW_NDCC0}, 1'b0, '0, 1'b0, '0, 1'b0, '0, STATUS_OK},
      '{KIND_AAP, '0, 1'b1, 64'hA5A5_A5A5_5A5A_5A5A, 1'b1, ADDR_T0_NDCC0,
        1'b0, '0, STATUS_OK},
      '{KIND_AAP, '0, 1'b1, 64'h0F0F_F0F0_0F0F_F0F0, 1'b1, ADDR_T1_NDCC1,
        1'b0, '0, STATUS_OK},
      '{KIND_AAP, '0, 1'b1, 64'h3333_CCCC_3333_CCCC, 1'b1, ADDR_T2_T3,
        1'b0, '0, STATUS_OK},
      '{KIND_AP, ADDR_T012, 1'b0, '0, 1'b0, '0, 1'b0, '0, STATUS_OK},
      '{KIND_AP, ADDR_T123, 1'b0, '0, 1'b0, '0, 1'b0, '0, STATUS_OK},
      '{KIND_AP, ADDR_DCC0_T12, 1'b0, '0, 1'b0, '0, 1'b0, '0, STATUS_OK},
      '{KIND_AP, ADDR_DCC1_T03, 1'b1, ALL_ONES, 1'b1, ADDR_T012, 1'b0, '0, STATUS_OK},
      '{KIND_AAP, ADDR_DCC1_T03, 1'b0, '0, 1'b0, '0, 1'b0, '0, STATUS_OK},
      '{KIND_AAP, ADDR_DCC0_T12, 1'b0, '0, 1'b1, ADDR_DCC0_T12, 1'b0, '0, STATUS_OK},
      '{KIND_AAP, {1'b0, ROW_NDCC1}, 1'b0, '0, 1'b1, {1'b0, ROW_NDCC0},
        1'b0, '0, STATUS_OK},
      '{KIND_AAP, '0, 1'b1, 64'h8000_0000_0000_0001, 1'b1, {1'b0, ROW_NDCC1},
        1'b0, '0, STATUS_OK},
      '{KIND_AAP, '0, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b1, ADDR_T0_T3,
        1'b0, '0, STATUS_OK},
      '{KIND_AAP, '0, 1'b1, 64'hFEDC_BA98_7654_3210, 1'b1, ADDR_DCC1_T03,
        1'b0, '0, STATUS_OK},
      '{KIND_AAP, {1'b0, ROW_DCC1}, 1'b0, '0, 1'b0, '0, 1'b0, '0, STATUS_OK}
   };

   always #(CLK_PERIOD / 2) clock = ~clock;

   dram_row_majority_compute #(
      .ROW_BITS (ROW_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // Majority of the row triplet behind an AP address; writes it back.
   function automatic logic [63:0] run_majority(input logic [3:0] addr);
      logic [2:0]  x;
      logic [2:0]  y;
      logic [2:0]  z;
      logic [63:0] m;
      case (addr)
         ADDR_T012: begin
            x = ROW_T0;   y = ROW_T1; z = ROW_T2;
         end
         ADDR_T123: begin
            x = ROW_T1;   y = ROW_T2; z = ROW_T3;
         end
         ADDR_DCC0_T12: begin
            x = ROW_DCC0; y = ROW_T1; z = ROW_T2;
         end
         default: begin
            x = ROW_DCC1; y = ROW_T0; z = ROW_T3;
         end
      endcase
      m = ((row_model[x] & row_model[y]) | (row_model[x] & row_model[z]) |
           (row_model[y] & row_model[z])) & ROW_MASK;
      row_model[x] = m;
      row_model[y] = m;
      row_model[z] = m;
      if (x == ROW_DCC0 || x == ROW_DCC1) row_model[x + 3'd1] = ~m & ROW_MASK;
      return m;
   endfunction

   function automatic void write_rows(input logic [3:0] dst, input logic [63:0] v);
      logic [63:0] nv;
      nv = ~v & ROW_MASK;
      case (dst)
         ADDR_T0_NDCC0: begin
            row_model[ROW_T0] = v; row_model[ROW_NDCC0] = v; row_model[ROW_DCC0] = nv;
         end
         ADDR_T1_NDCC1: begin
            row_model[ROW_T1] = v; row_model[ROW_NDCC1] = v; row_model[ROW_DCC1] = nv;
         end
         ADDR_T2_T3: begin
            row_model[ROW_T2] = v; row_model[ROW_T3] = v;
         end
         ADDR_T0_T3: begin
            row_model[ROW_T0] = v; row_model[ROW_T3] = v;
         end
         ADDR_T012: begin
            row_model[ROW_T0] = v; row_model[ROW_T1] = v; row_model[ROW_T2] = v;
         end
         ADDR_T123: begin
            row_model[ROW_T1] = v; row_model[ROW_T2] = v; row_model[ROW_T3] = v;
         end
         ADDR_DCC0_T12: begin
            row_model[ROW_DCC0] = v; row_model[ROW_T1] = v; row_model[ROW_T2] = v;
            row_model[ROW_NDCC0] = nv;
         end
         ADDR_DCC1_T03: begin
            row_model[ROW_DCC1] = v; row_model[ROW_T0] = v; row_model[ROW_T3] = v;
            row_model[ROW_NDCC1] = nv;
         end
         default: begin
            row_model[dst[2:0]] = v;
            // dual-contact rows: the partner takes the complement
            case (dst[2:0])
               ROW_DCC0:  row_model[ROW_NDCC0] = nv;
               ROW_NDCC0: row_model[ROW_DCC0]  = nv;
               ROW_DCC1:  row_model[ROW_NDCC1] = nv;
               ROW_NDCC1: row_model[ROW_DCC1]  = nv;
               default: ;
            endcase
         end
      endcase
   endfunction

   // Apply one command to the row file; tell whether it returns a result.
   function automatic bit execute_row_cmd(input req_type c, output rsp_type r);
      logic [63:0] v;
      bit          bad;
      r.data   = '0;
      r.status = STATUS_OK;
      bad      = 1'b0;
      v        = '0;
      if (c.kind == KIND_AP) begin
         if (c.source_address < ADDR_T012) r.status = STATUS_INVALID;
         else r.data = run_majority(c.source_address);
         return 1'b1;
      end
      if (c.source_external) v = c.external_value & ROW_MASK;
      else if (c.source_address >= ADDR_T012) v = run_majority(c.source_address);
      else if (c.source_address < NUM_ROWS) v = row_model[c.source_address[2:0]];
      else bad = 1'b1;
      if (bad) begin
         r.status = STATUS_INVALID;
         return 1'b1;
      end
      if (c.dest_valid) begin
         write_rows(c.dest_address, v);
         return 1'b0;
      end
      r.data = v;
      return 1'b1;
   endfunction

   function automatic req_type random_cmd();
      req_type c;
      int      pick;
      c.kind            = ($urandom_range(0, 99) < 35) ? KIND_AP : KIND_AAP;
      c.source_external = ($urandom_range(0, 9) < 3);
      c.dest_valid      = ($urandom_range(0, 9) < 6);
      c.dest_address    = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 9);
      if (pick < 5) c.source_address = 4'($urandom_range(ADDR_T012, ADDR_DCC1_T03));
      else if (pick < 9) c.source_address = 4'($urandom_range(0, NUM_ROWS - 1));
      else c.source_address = 4'($urandom_range(0, ADDR_T0_T3));
      case ($urandom_range(0, 7))
         0:       c.external_value = '0;
         1:       c.external_value = ALL_ONES;
         2:       c.external_value = 64'h1 << $urandom_range(0, 63);
         3:       c.external_value = ~(64'h1 << $urandom_range(0, 63));
         default: c.external_value = {$urandom(), $urandom()};
      endcase
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < MAX_REPORTS)
         $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Offer one command, hold it until the transfer, then predict its result.
   task automatic transfer_cmd(input req_type c, input bit typed, input rsp_type typed_rsp,
                               input bit hold);
      rsp_type predicted;
      bit      has_rsp;
      req       <= c;
      req_valid <= 1'b1;
      if (hold) hold_pulse <= 1'b1;
      // stall is settled mid-cycle; the transfer happens at the next rising edge
      @(negedge clock);
      while (req_stall) begin
         @(posedge clock);
         if (hold) hold_pulse <= 1'b0;
         @(negedge clock);
      end
      @(posedge clock);
      if (hold) hold_pulse <= 1'b0;
      has_rsp = execute_row_cmd(c, predicted);
      if (typed) predicted = typed_rsp;
      if (typed || has_rsp) begin
         pending_results.push_back(predicted);
         if (predicted.status == STATUS_INVALID) invalid_count++;
      end
      if (c.kind == KIND_AP) ap_count++;
      else aap_count++;
      if (!has_rsp) write_count++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      req_type     c;
      rsp_type     typed_rsp;
      dir_cmd_type d;
      for (int i = 0; i < NUM_ROWS; i++) row_model[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_cmds[i]) begin
         d = directed_cmds[i];
         c.kind            = d.kind;
         c.source_address  = d.src;
         c.source_external = d.ext;
         c.external_value  = d.value;
         c.dest_valid      = d.dv;
         c.dest_address    = d.dst;
         typed_rsp.data    = d.data;
         typed_rsp.status  = d.status;
         transfer_cmd(c, d.typed, typed_rsp, 1'b0);
      end

      typed_rsp = '0;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == PAUSE_AT) begin
            // drain everything before going on
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0) @(posedge clock);
         end
         if (n == CALM_FROM) idle_on <= 1'b0;
         transfer_cmd(random_cmd(), 1'b0, typed_rsp, n == HOLD_AT);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d commands: %0d AP, %0d AAP, %0d row writes with no result",
               ap_count + aap_count, ap_count, aap_count, write_count);
      $display("Checked %0d results, %0d of them invalid-address, %0d mismatches",
               checked_count, invalid_count, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Result side: check each transfer, then decide the next stall.
   always @(posedge clock) begin : result_side
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_count++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, data", rsp.data, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp.data !== want.data) report_mismatch("data", rsp.data, want.data);
            if (rsp.status !== want.status)
               report_mismatch("status", 64'(rsp.status), 64'(want.status));
         end
      end
      if (hold_pulse) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Stop a hung run: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

// ===== dram_row_majority_compute.f =====
hw/rtl/drmc_pkg.sv
hw/rtl/drmc_exec.sv
hw/rtl/dram_row_majority_compute.sv
sim/tb_dram_row_majority_compute.sv
